FILE: rtl/midi_arpeggiator_scheduler_top_macros.svh
// assertion macros for the arpeggiator scheduler
`ifndef MIDI_ARPEGGIATOR_SCHEDULER_TOP_MACROS_SVH
`define MIDI_ARPEGGIATOR_SCHEDULER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define MARP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MARP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MARP_ASSERT_ALWAYS(label, prop, msg)
`define MARP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/marp_pkg.sv
// shared types and constants of the arpeggiator scheduler
package marp_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int ARP_STEPS  = 4;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SCAN_W     = $clog2(SLOT_COUNT + 1);
    localparam int STEP_W     = (ARP_STEPS > 1) ? $clog2(ARP_STEPS) : 1;
    // wide enough for note + (ARP_STEPS) * interval without wrapping
    localparam int PITCH_W    = 8 + $clog2(ARP_STEPS);

    localparam logic [7:0]  NOTE_ON        = 8'h90;
    localparam logic [7:0]  NOTE_OFF       = 8'h80;
    localparam logic [7:0]  KIND_MASK      = 8'hF0;
    localparam logic [6:0]  NOTE_MAX       = 7'd127;
    localparam logic        KIND_TICK      = 1'b1;

    localparam logic [3:0]  RESET_CHANNEL  = 4'd0;
    localparam logic [15:0] RESET_STEP     = 16'd1000;
    localparam logic [6:0]  RESET_INTERVAL = 7'd4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  status;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] time_ms;
    } in_t;

    typedef struct packed {
        logic [7:0] out_status;
        logic [6:0] out_note;
        logic [6:0] out_velocity;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] stamp;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic              load;
        logic              wr_on;
        logic              wr_off;
        logic              step_adv;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              chk;
        logic              flush;
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic in_note_on;
        logic skip;
        logic hold;
        logic pend_valid;
    } stat_t;

endpackage

FILE: rtl/marp_ctrl.sv
// controller: sequences arpeggio writes and the slot scan of a tick
module marp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  marp_pkg::stat_t  st,
    output marp_pkg::cmd_t   cmd,
    output marp_pkg::state_t state
);

    marp_pkg::state_t                  state_reg, state_next;
    logic [marp_pkg::STEP_W-1:0]       step_reg, step_next;
    logic                              phase_reg, phase_next;
    logic [marp_pkg::SCAN_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                              chk_live_reg, chk_live_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= marp_pkg::ST_IDLE;
            step_reg     <= '0;
            phase_reg    <= 1'b0;
            scan_idx_reg <= '0;
            chk_live_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            scan_idx_reg <= scan_idx_next;
            chk_live_reg <= chk_live_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        phase_next    = phase_reg;
        scan_idx_next = scan_idx_reg;
        chk_live_next = chk_live_reg;
        cmd           = '0;
        cmd.rd_addr   = scan_idx_reg[marp_pkg::SLOT_W-1:0];
        in_stall      = (state_reg != marp_pkg::ST_IDLE);

        case (state_reg)
            marp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (st.in_tick)
                    begin
                        scan_idx_next = '0;
                        chk_live_next = 1'b0;
                        state_next    = marp_pkg::ST_SCAN;
                    end
                    else if (st.in_note_on)
                    begin
                        step_next  = '0;
                        phase_next = 1'b0;
                        state_next = marp_pkg::ST_GEN;
                    end
                end
            end

            marp_pkg::ST_GEN:
            begin
                if (!phase_reg && st.skip)
                begin
                    cmd.step_adv = 1'b1;
                end
                else if (!phase_reg)
                begin
                    cmd.wr_on  = 1'b1;
                    phase_next = 1'b1;
                end
                else
                begin
                    cmd.wr_off   = 1'b1;
                    cmd.step_adv = 1'b1;
                    phase_next   = 1'b0;
                end
                if (cmd.step_adv)
                begin
                    if (step_reg == marp_pkg::STEP_W'(marp_pkg::ARP_STEPS - 1))
                    begin
                        state_next = marp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end

            marp_pkg::ST_SCAN:
            begin
                // read of slot k overlaps the due check of slot k-1
                cmd.chk = chk_live_reg;
                if (!st.hold)
                begin
                    if (scan_idx_reg != marp_pkg::SCAN_W'(marp_pkg::SLOT_COUNT))
                    begin
                        cmd.rd_en     = 1'b1;
                        scan_idx_next = scan_idx_reg + 1'b1;
                        chk_live_next = 1'b1;
                    end
                    else
                    begin
                        chk_live_next = 1'b0;
                        if (!chk_live_reg)
                        begin
                            state_next = marp_pkg::ST_DRAIN;
                        end
                    end
                end
            end

            marp_pkg::ST_DRAIN:
            begin
                cmd.flush = 1'b1;
                if (!st.pend_valid)
                begin
                    state_next = marp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = marp_pkg::ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

FILE: rtl/marp_dp.sv
// datapath: config registers, slot memory, arpeggio arithmetic, output word
module marp_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  marp_pkg::cmd_t                     cmd,
    output marp_pkg::stat_t                    st,
    input  marp_pkg::in_t                      in_word,
    input  logic                               cfg_we,
    input  logic [marp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [marp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               out_stall,
    output logic                               out_valid,
    output marp_pkg::out_t                     out_word
);

    logic [3:0]                     channel_reg;
    logic [15:0]                    step_reg;
    logic [6:0]                     interval_reg;

    logic [6:0]                     vel_reg;
    logic [31:0]                    time_reg;
    logic [marp_pkg::PITCH_W-1:0]   pitch_reg;

    logic [marp_pkg::SLOT_W-1:0]    wr_ptr_reg;
    logic [marp_pkg::SLOT_COUNT-1:0] valid_reg;
    marp_pkg::slot_t                mem [marp_pkg::SLOT_COUNT];
    marp_pkg::slot_t                rdata_reg;
    logic                           rvalid_reg;
    logic [marp_pkg::SLOT_W-1:0]    raddr_reg;

    marp_pkg::out_t                 pend_reg;
    logic                           pend_valid_reg;
    logic                           out_valid_reg;
    marp_pkg::out_t                 out_reg;

    marp_pkg::slot_t                wdata;
    logic                           we;
    logic                           due;
    logic                           out_busy;
    logic                           hit;
    logic                           flush_go;
    logic [31:0]                    off_stamp;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg  <= marp_pkg::RESET_CHANNEL;
            step_reg     <= marp_pkg::RESET_STEP;
            interval_reg <= marp_pkg::RESET_INTERVAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                marp_pkg::CFG_CHANNEL:    channel_reg  <= cfg_data[3:0];
                marp_pkg::CFG_STEP_TICKS: step_reg     <= cfg_data[15:0];
                marp_pkg::CFG_INTERVAL:   interval_reg <= cfg_data[6:0];
                default:                  channel_reg  <= channel_reg;
            endcase
        end
    end

    // latched word and arpeggio accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vel_reg   <= in_word.velocity;
            time_reg  <= in_word.time_ms;
            pitch_reg <= marp_pkg::PITCH_W'(in_word.note);
        end
        else if (cmd.step_adv)
        begin
            time_reg  <= time_reg + {16'd0, step_reg};
            pitch_reg <= pitch_reg + marp_pkg::PITCH_W'(interval_reg);
        end
    end

    assign off_stamp = time_reg + {16'd0, step_reg};
    assign we        = cmd.wr_on | cmd.wr_off;

    always_comb
    begin
        wdata.status   = (cmd.wr_on ? marp_pkg::NOTE_ON : marp_pkg::NOTE_OFF)
                         | {4'd0, channel_reg};
        wdata.note     = pitch_reg[6:0];
        wdata.velocity = vel_reg;
        wdata.stamp    = cmd.wr_on ? time_reg : off_stamp;
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cmd.rd_addr];
            raddr_reg <= cmd.rd_addr;
        end
    end

    assign due      = rvalid_reg && (rdata_reg.stamp <= time_reg);
    assign out_busy = out_valid_reg && out_stall;
    assign hit      = cmd.chk && due && !st.hold;
    assign flush_go = cmd.flush && pend_valid_reg && !out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wr_ptr_reg] <= 1'b1;
                if (wr_ptr_reg == marp_pkg::SLOT_W'(marp_pkg::SLOT_COUNT - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (hit)
            begin
                valid_reg[raddr_reg] <= 1'b0;
            end
            if (cmd.rd_en)
            begin
                rvalid_reg <= valid_reg[cmd.rd_addr];
            end
        end
    end

    // one due event is held back until the next one shows it was not the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (hit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_go)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((hit && pend_valid_reg) || flush_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            pend_reg.out_status   <= rdata_reg.status;
            pend_reg.out_note     <= rdata_reg.note;
            pend_reg.out_velocity <= rdata_reg.velocity;
            pend_reg.last         <= 1'b0;
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
        end
        else if (flush_go)
        begin
            out_reg <= {pend_reg.out_status, pend_reg.out_note, pend_reg.out_velocity, 1'b1};
        end
    end

    always_comb
    begin
        st.in_tick    = (in_word.kind == marp_pkg::KIND_TICK);
        st.in_note_on = ((in_word.status & marp_pkg::KIND_MASK) == marp_pkg::NOTE_ON);
        st.skip       = (pitch_reg > marp_pkg::PITCH_W'(marp_pkg::NOTE_MAX));
        st.hold       = cmd.chk && due && pend_valid_reg && out_busy;
        st.pend_valid = pend_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

FILE: rtl/midi_arpeggiator_scheduler_top.sv
// top level of the midi arpeggiator scheduler
//
//   channel | signals                     | carries
//   --------+-----------------------------+-------------------------------------
//   in      | in_valid, in_stall, in_word | midi message or time tick word
//   out     | out_valid, out_stall, out_word | due note-on / note-off word, last flag
//   cfg     | cfg_we, cfg_index, cfg_data | channel, step_ticks, interval
//
// a note-on message is accepted and then makes up to 2*ARP_STEPS slot writes; other
// messages are only accepted; a tick reads all SLOT_COUNT slots and then drains,
// flushing the last word when something is due
// output stalls hold the scan when a second due word waits behind one, and hold
// the flush of the last word until the output register is free
// reset clears all slot valid bits at once; no clearing pass is needed
module midi_arpeggiator_scheduler_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  marp_pkg::in_t                      in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output marp_pkg::out_t                     out_word,
    input  logic                               cfg_we,
    input  logic [marp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [marp_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "midi_arpeggiator_scheduler_top_macros.svh"

    marp_pkg::cmd_t   cmd;
    marp_pkg::stat_t  st;
    marp_pkg::state_t state;
    logic             slot_wr;
    logic             scan_rd;
    logic             out_held;

    marp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd),
        .state    (state)
    );

    marp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

    assign slot_wr  = cmd.wr_on || cmd.wr_off;
    assign scan_rd  = cmd.rd_en || cmd.chk;
    assign out_held = out_valid && out_stall;

    // no word may be left held back once the block takes new input
    `MARP_ASSERT_ALWAYS(a_idle_no_pend, in_stall || !st.pend_valid, "pending word while idle")

    // a stalled word stays put
    `MARP_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "word moved")

    // slot writes and scan reads belong to different phases
    `MARP_ASSERT_ALWAYS(a_wr_rd_apart, !(slot_wr && scan_rd), "write during scan")

    // arpeggio writes only happen in the generation phase
    `MARP_ASSERT_ALWAYS(a_wr_in_gen, !slot_wr || state == marp_pkg::ST_GEN, "write outside gen")

endmodule

FILE: tb/sv/tb_midi_arpeggiator_scheduler_top.sv
// self-checking testbench of the midi arpeggiator scheduler top level
`timescale 1ns / 100ps

module tb_midi_arpeggiator_scheduler_top;
    import marp_pkg::*;

    localparam logic           KIND_MSG      = 1'b0;
    localparam logic [1:0]     CFG_NONE      = 2'd3;
    localparam int             TICK_WORDS    = 64;
    localparam int             IDLE_PAD      = 120;
    localparam int             HOLD_CYCLES   = 800;
    localparam int             CYCLE_LIMIT   = 600000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    in_t                       in_word = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_t                      out_word;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    // stimulus and expectation stores
    in_t                       pending_words[$];
    out_t                      due_words[$];
    out_t                      exp_word;
    logic                      in_fire = 1'b0;

    // predictor state
    logic                      slot_live [SLOT_COUNT];
    slot_t                     slot_data [SLOT_COUNT];
    int                        wr_pos;
    logic [3:0]                cur_channel;
    logic [15:0]               cur_step;
    logic [6:0]                cur_interval;

    // run control
    int                        send_idle_pct = 0;
    int                        stall_pct = 0;
    int                        hold_request = 0;
    int                        hold_seen = 0;
    int                        hold_left = 0;
    logic [31:0]               now_ms = '0;
    int                        fail_count = 0;
    int                        words_checked = 0;
    int                        notes_taken = 0;
    int                        ticks_taken = 0;
    int                        others_taken = 0;
    int                        cycle_count = 0;

    midi_arpeggiator_scheduler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void store_event(logic [7:0] st, logic [6:0] nt, logic [6:0] vel,
                                        logic [31:0] stamp);
        slot_data[wr_pos].status   = st;
        slot_data[wr_pos].note     = nt;
        slot_data[wr_pos].velocity = vel;
        slot_data[wr_pos].stamp    = stamp;
        slot_live[wr_pos]          = 1'b1;
        wr_pos = (wr_pos == SLOT_COUNT - 1) ? 0 : wr_pos + 1;
    endfunction

    // one note-on becomes a rising run of on/off pairs
    function automatic void arp_expand(in_t w);
        int          k;
        int          pitch;
        logic [31:0] on_stamp;
        for (k = 0; k < ARP_STEPS; k++)
        begin
            pitch    = int'(w.note) + k * int'(cur_interval);
            on_stamp = w.time_ms + 32'(k * int'(cur_step));
            if (pitch <= int'(NOTE_MAX))
            begin
                store_event(NOTE_ON | {4'h0, cur_channel}, 7'(pitch), w.velocity, on_stamp);
                store_event(NOTE_OFF | {4'h0, cur_channel}, 7'(pitch), w.velocity,
                            on_stamp + 32'(cur_step));
            end
        end
    endfunction

    function automatic void tick_release(logic [31:0] now);
        int   i;
        int   n;
        out_t w;
        n = 0;
        for (i = 0; i < SLOT_COUNT && n < TICK_WORDS; i++)
        begin
            if (slot_live[i] && slot_data[i].stamp <= now)
            begin
                w.out_status   = slot_data[i].status;
                w.out_note     = slot_data[i].note;
                w.out_velocity = slot_data[i].velocity;
                w.last         = 1'b0;
                due_words.push_back(w);
                slot_live[i] = 1'b0;
                n++;
            end
        end
        if (n > 0)
            due_words[due_words.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_word(logic kind, logic [7:0] st, logic [6:0] nt,
                                     logic [6:0] vel, logic [31:0] t);
        in_t w;
        w.kind     = kind;
        w.status   = st;
        w.note     = nt;
        w.velocity = vel;
        w.time_ms  = t;
        pending_words.push_back(w);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CHANNEL:    cur_channel  = val[3:0];
            CFG_STEP_TICKS: cur_step     = val;
            CFG_INTERVAL:   cur_interval = val[6:0];
            default: ;
        endcase
    endtask

    // drain everything, then give a silent tick scan or arpeggio time to finish
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    // mostly note-ons near the running time and ticks that walk it forward
    task automatic queue_random(int target);
        int          counted;
        int          pick;
        logic [7:0]  st;
        in_t         w;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                add_word(KIND_MSG, NOTE_ON | 8'($urandom_range(15)), 7'($urandom_range(127)),
                         7'($urandom_range(127)), now_ms + $urandom_range(300));
                counted++;
            end
            else if (pick < 80)
            begin
                now_ms = now_ms + $urandom_range(2 * int'(cur_step) + 50);
                add_word(KIND_TICK, 8'($urandom_range(255)), 7'($urandom_range(127)),
                         7'($urandom_range(127)), now_ms);
                counted++;
            end
            else if (pick < 90)
            begin
                st = 8'($urandom_range(255));
                while ((st & KIND_MASK) == NOTE_ON)
                    st = 8'($urandom_range(255));
                add_word(KIND_MSG, st, 7'($urandom_range(127)), 7'($urandom_range(127)),
                         $urandom());
                counted++;
            end
            else
            begin
                w = in_t'({$urandom(), $urandom()});
                pending_words.push_back(w);
                counted++;
            end
        end
    endtask

    // input side: offer words at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // accepted input words feed the predictor
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            if (in_word.kind == KIND_TICK)
            begin
                tick_release(in_word.time_ms);
                ticks_taken++;
            end
            else if ((in_word.status & KIND_MASK) == NOTE_ON)
            begin
                arp_expand(in_word);
                notes_taken++;
            end
            else
                others_taken++;
        end
    end

    // output side: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_request)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_words.size() == 0)
            begin
                $error("unexpected word: status %0h note %0d velocity %0d last %0b",
                       out_word.out_status, out_word.out_note, out_word.out_velocity,
                       out_word.last);
                fail_count++;
            end
            else
            begin
                exp_word = due_words.pop_front();
                if (out_word.out_status !== exp_word.out_status)
                begin
                    $error("out_status: expected %0h, got %0h",
                           exp_word.out_status, out_word.out_status);
                    fail_count++;
                end
                if (out_word.out_note !== exp_word.out_note)
                begin
                    $error("out_note: expected %0d, got %0d",
                           exp_word.out_note, out_word.out_note);
                    fail_count++;
                end
                if (out_word.out_velocity !== exp_word.out_velocity)
                begin
                    $error("out_velocity: expected %0d, got %0d",
                           exp_word.out_velocity, out_word.out_velocity);
                    fail_count++;
                end
                if (out_word.last !== exp_word.last)
                begin
                    $error("last: expected %0b, got %0b", exp_word.last, out_word.last);
                    fail_count++;
                end
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, due_words.size());
            $display("[midi_arpeggiator_scheduler_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int k;
        for (k = 0; k < SLOT_COUNT; k++)
        begin
            slot_live[k] = 1'b0;
            slot_data[k] = '0;
        end
        wr_pos       = 0;
        cur_channel  = RESET_CHANNEL;
        cur_step     = RESET_STEP;
        cur_interval = RESET_INTERVAL;

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, empty store, plain run, top note, zero velocity
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, 32'd0);
        add_word(KIND_MSG, 8'h90, 7'd60, 7'd100, 32'd0);
        add_word(KIND_MSG, 8'h80, 7'd60, 7'd0, 32'd10);
        add_word(KIND_TICK, 8'hFF, 7'd127, 7'd127, 32'd0);
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, 32'd1000);
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, 32'hFFFF_FFFF);
        add_word(KIND_MSG, 8'h9F, 7'd127, 7'd127, 32'd5);
        add_word(KIND_MSG, 8'h95, 7'd0, 7'd0, 32'd5);
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, 32'd3000);
        // stamps that wrap past the top of the time range
        add_word(KIND_MSG, 8'h90, 7'd1, 7'd1, 32'hFFFF_FE00);
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, 32'd500);
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, 32'hFFFF_FFFF);
        add_word(KIND_MSG, 8'hB0, 7'd7, 7'd64, 32'd0);
        add_word(KIND_MSG, 8'hF8, 7'd0, 7'd0, 32'hFFFF_FFFF);
        // more events than slots: the ring overwrites live entries
        for (k = 0; k < 9; k++)
            add_word(KIND_MSG, NOTE_ON | 8'(k), 7'(10 + k), 7'(k * 9), 32'h7000_0000 + k);
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, 32'hFFFF_FFFF);
        wait_idle();

        write_reg(CFG_CHANNEL, 16'd15);
        write_reg(CFG_STEP_TICKS, 16'd0);
        write_reg(CFG_INTERVAL, 16'd127);
        send_idle_pct = 86;
        stall_pct     = 0;
        queue_random(70);
        wait_idle();

        write_reg(CFG_CHANNEL, 16'd5);
        write_reg(CFG_STEP_TICKS, 16'hFFFF);
        write_reg(CFG_INTERVAL, 16'd0);
        send_idle_pct = 0;
        stall_pct     = 86;
        queue_random(70);
        wait_idle();

        write_reg(CFG_CHANNEL, 16'd9);
        write_reg(CFG_STEP_TICKS, 16'd1);
        write_reg(CFG_INTERVAL, 16'd1);
        send_idle_pct = 29;
        stall_pct     = 29;
        queue_random(70);
        wait_idle();

        // an out-of-range index must leave every register alone
        write_reg(CFG_NONE, 16'hFFFF);
        write_reg(CFG_CHANNEL, 16'd3);
        write_reg(CFG_STEP_TICKS, 16'd250);
        write_reg(CFG_INTERVAL, 16'd7);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = hold_request + 1;
        for (k = 0; k < 6; k++)
            add_word(KIND_MSG, NOTE_ON, 7'(20 + 5 * k), 7'(100 - k), now_ms);
        now_ms = now_ms + 32'd2000;
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, now_ms);
        queue_random(70);
        wait_idle();

        write_reg(CFG_CHANNEL, 16'd12);
        write_reg(CFG_STEP_TICKS, 16'd300);
        write_reg(CFG_INTERVAL, 16'd12);
        send_idle_pct = 29;
        stall_pct     = 29;
        now_ms        = 32'hFFFF_F000;
        queue_random(70);
        add_word(KIND_TICK, 8'h00, 7'd0, 7'd0, 32'hFFFF_FFFF);
        wait_idle();

        $display("took %0d note-ons, %0d ticks and %0d other messages; checked %0d event words",
                 notes_taken, ticks_taken, others_taken, words_checked);
        $display("settings spanned channel 0..15, step 0..65535, interval 0..127, with wrap");
        if (fail_count == 0)
            $display("[midi_arpeggiator_scheduler_top] OK");
        else
            $display("[midi_arpeggiator_scheduler_top] ERROR");
        $finish;
    end

endmodule
